// File: hw/rtl/pls_pkg.sv
// Shared types, constants and helpers for the positional list store.
// Depends on nothing; used by pls_ram's instantiation context and the top level.
package pls_pkg;

	// List sizing
	localparam int CAPACITY = 16;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// Field widths
	localparam int CMD_W    = 3;
	localparam int POS_W    = 5;
	localparam int WORD_W   = 32;
	localparam int STAT_W   = 2;

	// Width that holds both a position and a count for comparisons
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_MODIFY  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_OBSERVE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_FIND    = 3'd4;

	// Status codes
	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STAT_W-1:0] ST_NO_ENTRY = 2'd2;

	// Result of one request, built while the request is worked on
	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [POS_W-1:0]  found;
		logic [STAT_W-1:0] status;
	} res_t;

	// Single-precision NaN test on a raw word
	function automatic logic is_nan_word(input logic [WORD_W-1:0] w);
		return (w[30:23] == 8'hFF) && (w[22:0] != 23'd0);
	endfunction

	// IEEE equality: both zeros match, NaN never matches
	function automatic logic ieee_equal(input logic [WORD_W-1:0] a,
		input logic [WORD_W-1:0] b);
		logic both_zero;
		both_zero = ((a[30:0] | b[30:0]) == 31'd0);
		if (is_nan_word(a) || is_nan_word(b)) begin
			return 1'b0;
		end
		return both_zero || (a == b);
	endfunction

endpackage

// File: hw/rtl/positional_list_store.sv
// Top level of the positional list store: request sequencer around the word memory.
// Depends on pls_pkg and pls_ram.
//
//  channel   | handshake            | payload
//  ----------+----------------------+-----------------------------------------------
//  request   | req_valid, req_stall | command, position, value
//  response  | rsp_valid, rsp_stall | read_word, found_position, entry_count,
//            |                      | is_empty, status
//
// One request at a time. Modify, append, delete of the last entry, empty find, unused
// codes and rejects go straight to the finishing state; observe goes through a read
// state; insert or delete moving entries shifts them, and find scans up to a match.
// The single read port of the word memory moves or compares one entry a cycle.
// Reset clears the count and the control state; the word memory needs no clearing pass.
// A request is taken while a response waits on rsp_stall; its response waits behind it.
module positional_list_store (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [pls_pkg::CMD_W-1:0]     command,
	input  logic [pls_pkg::POS_W-1:0]     position,
	input  logic [pls_pkg::WORD_W-1:0]    value,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [pls_pkg::WORD_W-1:0]    read_word,
	output logic [pls_pkg::POS_W-1:0]     found_position,
	output logic [pls_pkg::POS_W-1:0]     entry_count,
	output logic                          is_empty,
	output logic [pls_pkg::STAT_W-1:0]    status
);

	localparam int ADDR_W = pls_pkg::ADDR_W;
	localparam int CNT_W  = pls_pkg::CNT_W;
	localparam int CMP_W  = pls_pkg::CMP_W;
	localparam int POS_W  = pls_pkg::POS_W;
	localparam int WORD_W = pls_pkg::WORD_W;

	// Sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SHIFT = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_READ  = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0]                  state_q, state_d;
	logic [CNT_W-1:0]            total_q;
	logic [CNT_W-1:0]            new_total_q, new_total_d;
	logic [CNT_W-1:0]            left_q, left_d;
	logic [ADDR_W-1:0]           ptr_q, ptr_d;
	logic [ADDR_W-1:0]           idx_q, idx_d;
	logic [ADDR_W-1:0]           addr_s1, addr_d;
	logic                        rd_v_s1;
	logic [pls_pkg::CMD_W-1:0]   cmd_q, cmd_d;
	logic [WORD_W-1:0]           val_q, val_d;
	pls_pkg::res_t               pend_q, pend_d;

	logic                        issue;
	logic                        ram_we;
	logic [ADDR_W-1:0]           ram_waddr;
	logic [WORD_W-1:0]           ram_wdata;
	logic [ADDR_W-1:0]           ram_raddr;
	logic [WORD_W-1:0]           ram_rdata;

	logic                        load_out;
	logic                        out_valid_q;
	logic [WORD_W-1:0]           word_q;
	logic [POS_W-1:0]            found_q;
	logic [POS_W-1:0]            count_q;
	logic                        empty_q;
	logic [pls_pkg::STAT_W-1:0]  status_q;

	logic [CMP_W-1:0]            pidx;
	logic [CMP_W-1:0]            total_w;
	logic [CMP_W-1:0]            ins_idx;
	logic                        is_insert;
	logic                        match;

	pls_ram #(
		.DEPTH (pls_pkg::CAPACITY),
		.WIDTH (WORD_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (issue),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	// Decode position into a 0-based index, clamped at the head
	assign pidx    = (position == '0) ? '0 : CMP_W'(position - POS_W'(1));
	assign total_w = CMP_W'(total_q);
	assign ins_idx = (pidx > total_w) ? total_w : pidx;
	assign is_insert = (cmd_q == pls_pkg::CMD_INSERT);
	assign match     = rd_v_s1 && pls_pkg::ieee_equal(ram_rdata, val_q);

	assign req_stall = (state_q != S_IDLE);
	assign load_out  = (state_q == S_DONE) && (!out_valid_q || !rsp_stall);

	// Sequence one request through the memory
	always_comb begin
		state_d     = state_q;
		new_total_d = new_total_q;
		left_d      = left_q;
		ptr_d       = ptr_q;
		idx_d       = idx_q;
		addr_d      = addr_s1;
		cmd_d       = cmd_q;
		val_d       = val_q;
		pend_d      = pend_q;
		issue       = 1'b0;
		ram_raddr   = ptr_q;
		ram_we      = 1'b0;
		ram_waddr   = idx_q;
		ram_wdata   = val_q;

		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd_d       = command;
					val_d       = value;
					pend_d      = '{word: '0, found: '0, status: pls_pkg::ST_OK};
					new_total_d = total_q;
					state_d     = S_DONE;
					unique case (command)
						pls_pkg::CMD_INSERT: begin
							if (total_w >= CMP_W'(pls_pkg::CAPACITY)) begin
								pend_d.status = pls_pkg::ST_FULL;
							end else begin
								new_total_d = total_q + CNT_W'(1);
								idx_d       = ADDR_W'(ins_idx);
								if (ins_idx == total_w) begin
									ram_we    = 1'b1;
									ram_waddr = ADDR_W'(ins_idx);
									ram_wdata = value;
								end else begin
									issue     = 1'b1;
									ram_raddr = ADDR_W'(total_q - CNT_W'(1));
									addr_d    = ram_raddr + ADDR_W'(1);
									ptr_d     = ram_raddr - ADDR_W'(1);
									left_d    = CNT_W'(total_w - ins_idx - CMP_W'(1));
									state_d   = S_SHIFT;
								end
							end
						end
						pls_pkg::CMD_DELETE: begin
							if (pidx >= total_w) begin
								pend_d.status = pls_pkg::ST_NO_ENTRY;
							end else begin
								new_total_d = total_q - CNT_W'(1);
								if (pidx + CMP_W'(1) != total_w) begin
									issue     = 1'b1;
									ram_raddr = ADDR_W'(pidx + CMP_W'(1));
									addr_d    = ADDR_W'(pidx);
									ptr_d     = ram_raddr + ADDR_W'(1);
									left_d    = CNT_W'(total_w - pidx - CMP_W'(2));
									state_d   = S_SHIFT;
								end
							end
						end
						pls_pkg::CMD_MODIFY: begin
							if (pidx >= total_w) begin
								pend_d.status = pls_pkg::ST_NO_ENTRY;
							end else begin
								ram_we    = 1'b1;
								ram_waddr = ADDR_W'(pidx);
								ram_wdata = value;
							end
						end
						pls_pkg::CMD_OBSERVE: begin
							if (pidx >= total_w) begin
								pend_d.status = pls_pkg::ST_NO_ENTRY;
							end else begin
								issue     = 1'b1;
								ram_raddr = ADDR_W'(pidx);
								state_d   = S_READ;
							end
						end
						pls_pkg::CMD_FIND: begin
							if (total_q != '0) begin
								issue     = 1'b1;
								ram_raddr = '0;
								addr_d    = '0;
								ptr_d     = ADDR_W'(1);
								left_d    = total_q - CNT_W'(1);
								state_d   = S_SCAN;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_SHIFT: begin
				// Write back the word read last cycle one place over
				if (rd_v_s1) begin
					ram_we    = 1'b1;
					ram_waddr = addr_s1;
					ram_wdata = ram_rdata;
				end
				if (left_q != '0) begin
					issue     = 1'b1;
					ram_raddr = ptr_q;
					addr_d    = is_insert ? ptr_q + ADDR_W'(1) : ptr_q - ADDR_W'(1);
					ptr_d     = is_insert ? ptr_q - ADDR_W'(1) : ptr_q + ADDR_W'(1);
					left_d    = left_q - CNT_W'(1);
				end else if (!rd_v_s1) begin
					// Drop the new word into the opened slot
					if (is_insert) begin
						ram_we    = 1'b1;
						ram_waddr = idx_q;
						ram_wdata = val_q;
					end
					state_d = S_DONE;
				end
			end
			S_SCAN: begin
				if (match) begin
					pend_d.found = POS_W'(CNT_W'(addr_s1) + CNT_W'(1));
					state_d      = S_DONE;
				end else if (left_q != '0) begin
					issue     = 1'b1;
					ram_raddr = ptr_q;
					addr_d    = ptr_q;
					ptr_d     = ptr_q + ADDR_W'(1);
					left_d    = left_q - CNT_W'(1);
				end else if (!rd_v_s1) begin
					state_d = S_DONE;
				end
			end
			S_READ: begin
				pend_d.word = ram_rdata;
				state_d     = S_DONE;
			end
			S_DONE: begin
				if (load_out) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			total_q     <= '0;
			left_q      <= '0;
			ptr_q       <= '0;
			rd_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			left_q  <= left_d;
			ptr_q   <= ptr_d;
			rd_v_s1 <= issue;
			if (load_out) begin
				total_q     <= new_total_q;
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request and response payload
	always_ff @(posedge clk) begin
		new_total_q <= new_total_d;
		idx_q       <= idx_d;
		addr_s1     <= addr_d;
		cmd_q       <= cmd_d;
		val_q       <= val_d;
		pend_q      <= pend_d;
		if (load_out) begin
			word_q   <= pend_q.word;
			found_q  <= pend_q.found;
			status_q <= pend_q.status;
			count_q  <= POS_W'(new_total_q);
			empty_q  <= (new_total_q == '0);
		end
	end

	assign rsp_valid      = out_valid_q;
	assign read_word      = word_q;
	assign found_position = found_q;
	assign entry_count    = count_q;
	assign is_empty       = empty_q;
	assign status         = status_q;

	// Count never passes capacity
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(total_q) <= CMP_W'(pls_pkg::CAPACITY))
		else $error("entry count above capacity");

	// A read and a write never hit the same entry in one cycle
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && issue) |-> (ram_waddr != ram_raddr))
		else $error("read and write to one entry in the same cycle");

	// Read data is only pending while the sequencer consumes it
	a_read_owner: assert property (@(posedge clk) disable iff (!arst_n)
		rd_v_s1 |-> (state_q == S_SHIFT || state_q == S_SCAN || state_q == S_READ))
		else $error("memory read data left unconsumed");

	// A response appears only out of the finishing state
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_DONE))
		else $error("response raised outside finish");

endmodule

// File: hw/rtl/pls_ram.sv
// Simple dual-port word memory: one write and one registered read per cycle.
// No dependencies; contents are undefined until written.
module pls_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port, registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
